// ===== rtl/wsfd_pkg.sv =====
// Shared types, codes and helpers for the WebSocket frame decoder.
// No dependencies; compile first.
package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_BYTE0,
    PH_BYTE1,
    PH_EXTLEN,
    PH_KEY,
    PH_PAYLOAD,
    PH_DEAD
  } phase_t;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // Extended-length and masking-key byte counts minus one, loaded after the length code.
  localparam logic [2:0] EXT16_COUNT = 3'd1;
  localparam logic [2:0] EXT64_COUNT = 3'd7;
  localparam logic [2:0] KEY_COUNT   = 3'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] frame_length;
    logic [7:0]  data_byte;
    logic        last_of_frame;
  } result_t;

  function automatic logic opcode_valid(input logic [3:0] op);
    opcode_valid = (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BIN) ||
                   (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
  endfunction

endpackage

// ===== rtl/wsfd_if.sv =====
// Valid/ready channel interfaces for the frame decoder: raw bytes in, results out.
// No dependencies.
interface wsfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface wsfd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        fin;
  logic [3:0]  opcode;
  logic        masked;
  logic [63:0] frame_length;
  logic [7:0]  data_byte;
  logic        last_of_frame;

  modport source (output valid, output kind, output fin, output opcode, output masked,
                  output frame_length, output data_byte, output last_of_frame,
                  input ready);
  modport sink   (input valid, input kind, input fin, input opcode, input masked,
                  input frame_length, input data_byte, input last_of_frame,
                  output ready);
endinterface

// ===== rtl/websocket_frame_decoder_core.sv =====
// Top level of the WebSocket frame decoder: input register, parser, result register.
// Depends on wsfd_pkg, wsfd_if (wsfd_byte_if, wsfd_result_if) and wsfd_parser.
//
//   channel | dir | payload                                          | per transfer
//   rx      | in  | in_byte                                          | one stream byte
//   tx      | out | kind fin opcode masked frame_length data_byte    | zero or one result
//           |     | last_of_frame                                    |
//
// One byte per cycle while tx is not stalled; an accepted byte goes through the input
// register, then the parser logic into the result register, before tx.valid rises.
// Synchronous active-high rst returns the parser to the first header byte and
// empties both registers.
// A held result stalls the input register, and rx.ready drops once that is full.
module websocket_frame_decoder_core (
  input logic          clk,
  input logic          rst,
  wsfd_byte_if.sink    rx,
  wsfd_result_if.source tx
);

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              out_valid;
  wsfd_pkg::result_t out_res;
  logic              out_free;
  logic              step;
  logic              emit;
  wsfd_pkg::result_t res;

  assign out_free = !out_valid || tx.ready;
  assign step     = s1_valid && out_free;
  assign rx.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.in_byte;
    end
  end

  wsfd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (s1_byte),
    .emit    (emit),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && emit;
    end
  end

  // hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_res <= res;
    end
  end

  assign tx.valid         = out_valid;
  assign tx.kind          = out_res.kind;
  assign tx.fin           = out_res.fin;
  assign tx.opcode        = out_res.opcode;
  assign tx.masked        = out_res.masked;
  assign tx.frame_length  = out_res.frame_length;
  assign tx.data_byte     = out_res.data_byte;
  assign tx.last_of_frame = out_res.last_of_frame;

endmodule

// ===== rtl/wsfd_parser.sv =====
// Frame parser state and per-byte update: header fields, extended length,
// masking key and payload unmasking. Depends on wsfd_pkg.
module wsfd_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          in_byte,
  output logic                emit,
  output wsfd_pkg::result_t   res
);

  wsfd_pkg::phase_t phase, phase_next;
  logic        frame_fin, frame_fin_next;
  logic [3:0]  frame_opcode, frame_opcode_next;
  logic        frame_masked, frame_masked_next;
  logic [63:0] length_acc, length_acc_next;
  logic [2:0]  header_byte_count, header_byte_count_next;
  logic [31:0] mask_key, mask_key_next;
  logic [63:0] remaining, remaining_next;
  logic [1:0]  key_index, key_index_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= wsfd_pkg::PH_BYTE0;
      frame_fin         <= 1'b0;
      frame_opcode      <= '0;
      frame_masked      <= 1'b0;
      length_acc        <= '0;
      header_byte_count <= '0;
      mask_key          <= '0;
      remaining         <= '0;
      key_index         <= '0;
    end else if (step) begin
      phase             <= phase_next;
      frame_fin         <= frame_fin_next;
      frame_opcode      <= frame_opcode_next;
      frame_masked      <= frame_masked_next;
      length_acc        <= length_acc_next;
      header_byte_count <= header_byte_count_next;
      mask_key          <= mask_key_next;
      remaining         <= remaining_next;
      key_index         <= key_index_next;
    end
  end

  logic [6:0] len_code;
  logic [7:0] key_byte;
  logic       len_done;
  logic       hdr_done;
  logic       pay_last;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic       last_flag;

  assign len_code = in_byte[6:0];
  assign pay_last = (remaining <= 64'd1);

  always_comb begin
    case (key_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next             = phase;
    frame_fin_next         = frame_fin;
    frame_opcode_next      = frame_opcode;
    frame_masked_next      = frame_masked;
    length_acc_next        = length_acc;
    header_byte_count_next = header_byte_count;
    mask_key_next          = mask_key;
    remaining_next         = remaining;
    key_index_next         = key_index;
    len_done               = 1'b0;
    hdr_done               = 1'b0;
    emit                   = 1'b0;
    kind                   = wsfd_pkg::KIND_HEADER;
    data_byte              = 8'd0;
    last_flag              = 1'b0;

    case (phase)
      wsfd_pkg::PH_BYTE0: begin
        frame_fin_next    = in_byte[7];
        frame_opcode_next = in_byte[3:0];
        frame_masked_next = 1'b0;
        length_acc_next   = '0;
        if (!wsfd_pkg::opcode_valid(in_byte[3:0])) begin
          emit       = 1'b1;
          kind       = wsfd_pkg::KIND_ERROR;
          phase_next = wsfd_pkg::PH_DEAD;
        end else begin
          phase_next = wsfd_pkg::PH_BYTE1;
        end
      end
      wsfd_pkg::PH_BYTE1: begin
        frame_masked_next = in_byte[7];
        if (len_code == wsfd_pkg::LEN_CODE_16 || len_code == wsfd_pkg::LEN_CODE_64) begin
          length_acc_next        = '0;
          header_byte_count_next = (len_code == wsfd_pkg::LEN_CODE_16) ?
                                   wsfd_pkg::EXT16_COUNT : wsfd_pkg::EXT64_COUNT;
          phase_next             = wsfd_pkg::PH_EXTLEN;
        end else begin
          length_acc_next = {57'd0, len_code};
          len_done        = 1'b1;
        end
      end
      wsfd_pkg::PH_EXTLEN: begin
        length_acc_next = {length_acc[55:0], in_byte};
        if (header_byte_count != 3'd0) begin
          header_byte_count_next = header_byte_count - 3'd1;
        end else begin
          len_done = 1'b1;
        end
      end
      wsfd_pkg::PH_KEY: begin
        mask_key_next = {mask_key[23:0], in_byte};
        if (header_byte_count != 3'd0) begin
          header_byte_count_next = header_byte_count - 3'd1;
        end else begin
          hdr_done = 1'b1;
        end
      end
      wsfd_pkg::PH_PAYLOAD: begin
        emit           = 1'b1;
        kind           = wsfd_pkg::KIND_PAYLOAD;
        data_byte      = frame_masked ? (in_byte ^ key_byte) : in_byte;
        last_flag      = pay_last;
        remaining_next = pay_last ? 64'd0 : remaining - 64'd1;
        key_index_next = key_index + 2'd1;
        if (pay_last) begin
          phase_next = wsfd_pkg::PH_BYTE0;
        end
      end
      default: begin
        // dead after a bad opcode: drop every byte
      end
    endcase

    // Length known: collect the key if masked, else the header is complete.
    if (len_done) begin
      if (frame_masked_next) begin
        mask_key_next          = '0;
        header_byte_count_next = wsfd_pkg::KEY_COUNT;
        phase_next             = wsfd_pkg::PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      emit           = 1'b1;
      kind           = wsfd_pkg::KIND_HEADER;
      last_flag      = (length_acc_next == 64'd0);
      remaining_next = length_acc_next;
      key_index_next = 2'd0;
      phase_next     = (length_acc_next == 64'd0) ? wsfd_pkg::PH_BYTE0 :
                                                    wsfd_pkg::PH_PAYLOAD;
    end
  end

  always_comb begin
    res.kind          = kind;
    res.fin           = frame_fin_next;
    res.opcode        = frame_opcode_next;
    res.masked        = frame_masked_next;
    res.frame_length  = length_acc_next;
    res.data_byte     = data_byte;
    res.last_of_frame = last_flag;
  end

endmodule

// ===== sim/websocket_frame_decoder_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for websocket_frame_decoder_core: streams RFC 6455 frames
// with random pacing and output stalls, and checks every result against a frame parser.
// Depends on wsfd_pkg, wsfd_if and the decoder RTL.
module websocket_frame_decoder_core_test;

  localparam int RANDOM_BYTES = 1500;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;

  typedef enum {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;
  typedef enum {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PATTERN} stall_mode_t;

  // Expected-result store plus a byte-level frame parser that fills it.
  class frame_scoreboard;
    wsfd_pkg::phase_t  state;
    logic              cur_fin;
    logic [3:0]        cur_op;
    logic              cur_masked;
    logic [63:0]       cur_len;
    logic [2:0]        bytes_left;
    logic [31:0]       key;
    logic [63:0]       payload_left;
    logic [1:0]        key_pos;
    wsfd_pkg::result_t expected_q[$];
    int                errors;
    int                headers_seen;
    int                payload_seen;
    int                errors_seen;

    function new();
      state        = wsfd_pkg::PH_BYTE0;
      cur_fin      = 1'b0;
      cur_op       = 4'h0;
      cur_masked   = 1'b0;
      cur_len      = 64'd0;
      bytes_left   = 3'd0;
      key          = 32'd0;
      payload_left = 64'd0;
      key_pos      = 2'd0;
      errors       = 0;
      headers_seen = 0;
      payload_seen = 0;
      errors_seen  = 0;
    endfunction

    static function bit known_op(logic [3:0] op);
      case (op)
        wsfd_pkg::OP_CONT, wsfd_pkg::OP_TEXT, wsfd_pkg::OP_BIN,
        wsfd_pkg::OP_CLOSE, wsfd_pkg::OP_PING, wsfd_pkg::OP_PONG: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function void push_result(logic [1:0] kind, logic [7:0] data, logic last);
      wsfd_pkg::result_t r;
      r.kind          = kind;
      r.fin           = cur_fin;
      r.opcode        = cur_op;
      r.masked        = cur_masked;
      r.frame_length  = cur_len;
      r.data_byte     = data;
      r.last_of_frame = last;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void close_header();
      logic empty;
      empty = (cur_len == 64'd0);
      push_result(wsfd_pkg::KIND_HEADER, 8'h00, empty);
      payload_left = cur_len;
      key_pos      = 2'd0;
      if (empty) state = wsfd_pkg::PH_BYTE0;
      else state = wsfd_pkg::PH_PAYLOAD;
    endfunction

    function void close_length();
      if (cur_masked) begin
        key        = 32'd0;
        bytes_left = wsfd_pkg::KEY_COUNT;
        state      = wsfd_pkg::PH_KEY;
      end else begin
        close_header();
      end
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0] d;
      logic       last;
      case (state)
        wsfd_pkg::PH_BYTE0: begin
          cur_fin    = b[7];
          cur_op     = b[3:0];
          cur_masked = 1'b0;
          cur_len    = 64'd0;
          if (!known_op(cur_op)) begin
            push_result(wsfd_pkg::KIND_ERROR, 8'h00, 1'b0);
            state = wsfd_pkg::PH_DEAD;
          end else begin
            state = wsfd_pkg::PH_BYTE1;
          end
        end
        wsfd_pkg::PH_BYTE1: begin
          cur_masked = b[7];
          if (b[6:0] == wsfd_pkg::LEN_CODE_16 || b[6:0] == wsfd_pkg::LEN_CODE_64) begin
            cur_len = 64'd0;
            if (b[6:0] == wsfd_pkg::LEN_CODE_16) bytes_left = wsfd_pkg::EXT16_COUNT;
            else bytes_left = wsfd_pkg::EXT64_COUNT;
            state = wsfd_pkg::PH_EXTLEN;
          end else begin
            cur_len = {57'd0, b[6:0]};
            close_length();
          end
        end
        wsfd_pkg::PH_EXTLEN: begin
          cur_len = {cur_len[55:0], b};
          if (bytes_left != 3'd0) bytes_left = bytes_left - 3'd1;
          else close_length();
        end
        wsfd_pkg::PH_KEY: begin
          key = {key[23:0], b};
          if (bytes_left != 3'd0) bytes_left = bytes_left - 3'd1;
          else close_header();
        end
        wsfd_pkg::PH_PAYLOAD: begin
          d = b;
          // key byte 0 is the first key byte on the wire, i.e. the top byte
          if (cur_masked) d = d ^ key[8 * (3 - key_pos) +: 8];
          last = (payload_left <= 64'd1);
          push_result(wsfd_pkg::KIND_PAYLOAD, d, last);
          payload_left = payload_left - 64'd1;
          key_pos      = key_pos + 2'd1;
          if (last) begin
            payload_left = 64'd0;
            state        = wsfd_pkg::PH_BYTE0;
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task check_result(wsfd_pkg::result_t got);
      wsfd_pkg::result_t want;
      string             bad;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected: kind=%0d len=%h data=%h",
                         got.kind, got.frame_length, got.data_byte));
        return;
      end
      want = expected_q.pop_front();
      if (want.kind == wsfd_pkg::KIND_HEADER) headers_seen++;
      else if (want.kind == wsfd_pkg::KIND_PAYLOAD) payload_seen++;
      else errors_seen++;
      bad = "";
      if (got.kind !== want.kind) bad = {bad, " kind"};
      if (got.fin !== want.fin) bad = {bad, " fin"};
      if (got.opcode !== want.opcode) bad = {bad, " opcode"};
      if (got.masked !== want.masked) bad = {bad, " masked"};
      if (got.frame_length !== want.frame_length) bad = {bad, " frame_length"};
      if (got.data_byte !== want.data_byte) bad = {bad, " data_byte"};
      if (got.last_of_frame !== want.last_of_frame) bad = {bad, " last_of_frame"};
      if (bad != "")
        report($sformatf({"bad%s: want k%0d f%0d op%h m%0d len%h d%h l%0d",
                          " got k%0d f%0d op%h m%0d len%h d%h l%0d"},
                         bad, want.kind, want.fin, want.opcode, want.masked,
                         want.frame_length, want.data_byte, want.last_of_frame,
                         got.kind, got.fin, got.opcode, got.masked,
                         got.frame_length, got.data_byte, got.last_of_frame));
    endtask
  endclass

  logic clk;
  logic rst;
  int   cycles;
  int   sent;
  int   hold_off;
  int   burst_left;
  frame_scoreboard sb;

  wsfd_byte_if   rx_ch();
  wsfd_result_if tx_ch();

  websocket_frame_decoder_core uut (
    .clk(clk),
    .rst(rst),
    .rx (rx_ch),
    .tx (tx_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Sample both channels before the edge updates land.
  always @(posedge clk) begin
    wsfd_pkg::result_t got;
    if (!rst) begin
      if (tx_ch.valid && tx_ch.ready) begin
        got.kind          = tx_ch.kind;
        got.fin           = tx_ch.fin;
        got.opcode        = tx_ch.opcode;
        got.masked        = tx_ch.masked;
        got.frame_length  = tx_ch.frame_length;
        got.data_byte     = tx_ch.data_byte;
        got.last_of_frame = tx_ch.last_of_frame;
        sb.check_result(got);
      end
      if (rx_ch.valid && rx_ch.ready) sb.note_byte(rx_ch.in_byte);
    end
  end

  // Result side: stall in modes of random length; a requested hold-off wins.
  initial begin
    stall_mode_t mode;
    int          span;
    logic [7:0]  pat;
    tx_ch.ready = 1'b0;
    mode = RX_OPEN;
    span = 0;
    pat  = 8'hFF;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        hold_off--;
        tx_ch.ready <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          span = $urandom_range(8, 80);
          pat  = 8'($urandom);
        end
        span--;
        case (mode)
          RX_OPEN:   tx_ch.ready <= 1'b1;
          RX_COIN:   tx_ch.ready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: tx_ch.ready <= ($urandom_range(0, 7) != 0);
          default:   tx_ch.ready <= pat[span[2:0]];
        endcase
      end
    end
  end

  // Insert a random gap at the start of each burst; no gaps during a hold-off.
  task automatic pace();
    int gap;
    if (hold_off > 0) return;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      case ($urandom_range(0, 7))
        0, 1:    gap = 0;
        7:       gap = $urandom_range(16, 40);
        default: gap = $urandom_range(1, 5);
      endcase
      if (gap > 0) begin
        rx_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // Call at a falling edge; returns at the falling edge after the transfer.
  task automatic put_byte(logic [7:0] b);
    pace();
    rx_ch.valid   <= 1'b1;
    rx_ch.in_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_frame(logic [7:0] head, bit mask_on, len_form_t form,
                            logic [63:0] len, logic [31:0] mkey, int body, bit rail_fill);
    int i;
    put_byte(head);
    case (form)
      LEN_SHORT: put_byte({mask_on, len[6:0]});
      LEN_EXT16: begin
        put_byte({mask_on, wsfd_pkg::LEN_CODE_16});
        put_byte(len[15:8]);
        put_byte(len[7:0]);
      end
      default: begin
        put_byte({mask_on, wsfd_pkg::LEN_CODE_64});
        for (i = 7; i >= 0; i--) put_byte(len[8 * i +: 8]);
      end
    endcase
    if (mask_on)
      for (i = 3; i >= 0; i--) put_byte(mkey[8 * i +: 8]);
    for (i = 0; i < body; i++) begin
      if (rail_fill) put_byte((i % 2 == 0) ? 8'hFF : 8'h00);
      else put_byte(8'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [3:0]  good_ops [6];
    logic [3:0]  op;
    logic [7:0]  head;
    logic [63:0] len;
    logic [31:0] mkey;
    len_form_t   form;
    bit          mask_on;
    bit          paused;
    bit          held;
    bit          end_huge;
    int          pick;
    int          i;
    good_ops = '{wsfd_pkg::OP_CONT, wsfd_pkg::OP_TEXT, wsfd_pkg::OP_BIN,
                 wsfd_pkg::OP_CLOSE, wsfd_pkg::OP_PING, wsfd_pkg::OP_PONG};
    paused        = 1'b0;
    held          = 1'b0;
    cycles        = 0;
    sent          = 0;
    hold_off      = 0;
    burst_left    = 0;
    sb            = new();
    rx_ch.valid   = 1'b0;
    rx_ch.in_byte = 8'h00;
    rst           = 1'b1;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed: each opcode, zero length, masked empty frame, RSV bits, all length forms.
    send_frame(8'h81, 1'b0, LEN_SHORT, 64'd0, 32'h0, 0, 1'b0);
    send_frame(8'h02, 1'b1, LEN_SHORT, 64'd1, 32'hFFFF_FFFF, 1, 1'b1);
    send_frame(8'h80, 1'b0, LEN_SHORT, 64'd2, 32'h0, 2, 1'b1);
    send_frame(8'h88, 1'b1, LEN_EXT16, 64'd0, 32'h0, 0, 1'b0);
    send_frame(8'hF9, 1'b0, LEN_EXT16, 64'd1, 32'h0, 1, 1'b0);
    send_frame(8'h8A, 1'b1, LEN_EXT64, 64'd1, 32'($urandom), 1, 1'b0);

    // Random well-formed frames, mostly short, with non-minimal length encodings.
    while (sent < RANDOM_BYTES) begin
      if (!paused && sent >= 400) begin
        paused = 1'b1;
        rx_ch.valid <= 1'b0;
        wait_drained();
      end
      if (!held && sent >= 800) begin
        held     = 1'b1;
        hold_off = HOLD_CYCLES;
      end
      op      = good_ops[$urandom_range(0, 5)];
      head    = {1'($urandom), 3'($urandom), op};
      mask_on = 1'($urandom);
      mkey    = ($urandom_range(0, 9) == 0) ? 32'h0 : 32'($urandom);
      pick    = $urandom_range(0, 99);
      if (pick < 80) begin
        form = LEN_SHORT;
        len  = 64'($urandom_range(0, 6));
      end else if (pick < 92) begin
        form = LEN_SHORT;
        len  = 64'($urandom_range(7, 125));
      end else if (pick < 97) begin
        form = LEN_EXT16;
        len  = 64'($urandom_range(0, 300));
      end else begin
        form = LEN_EXT64;
        len  = 64'($urandom_range(0, 12));
      end
      send_frame(head, mask_on, form, len, mkey, int'(len), 1'b0);
    end

    // Both endings lock the parser for good, so pick one per run.
    end_huge = 1'($urandom_range(0, 1));
    if (end_huge) begin
      len     = {32'($urandom), 32'($urandom)};
      len[63] = 1'b1;
      send_frame({1'($urandom), 3'($urandom), good_ops[$urandom_range(0, 5)]},
                 1'($urandom), LEN_EXT64, len, 32'($urandom), 20, 1'b0);
    end else begin
      do op = 4'($urandom); while (frame_scoreboard::known_op(op));
      put_byte({1'($urandom), 3'($urandom), op});
      // drop everything after the bad opcode
      for (i = 0; i < 16; i++) put_byte(8'($urandom));
    end

    rx_ch.valid <= 1'b0;
    wait_drained();
    repeat (16) @(negedge clk);

    $display("run: %0d bytes in, %0d headers, %0d payload bytes, %0d opcode errors checked",
             sent, sb.headers_seen, sb.payload_seen, sb.errors_seen);
    $display("run: ended on %s, %0d mismatches",
             end_huge ? "a 64-bit length with the top bit set" : "an undefined opcode",
             sb.errors);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/wsfd_pkg.sv
rtl/wsfd_if.sv
rtl/wsfd_parser.sv
rtl/websocket_frame_decoder_core.sv
sim/websocket_frame_decoder_core_test.sv
